// ===== rtl/arp_set_assoc_table_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ARP set-associative table.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message string.
// ----------------------------------------------------------------------------
`ifndef ARP_SET_ASSOC_TABLE_DEFINES_SVH
`define ARP_SET_ASSOC_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/arp_sat_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP table package
// Item types, entry layout, opcodes, status codes and the hash mixing step.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_sat_pkg;

	// Opcodes of an input item.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// Status codes of a result item.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_SET_FULL  = 2'd2;

	// Hash seed: 0xdeadbeef plus two words times four, initval zero.
	localparam logic [31:0] HASH_INIT = 32'hdeadbef7;
	localparam int          MIX_STEPS = 7;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] ip_address;
		logic [15:0] vrf_id;
		logic [7:0]  port_in;
		logic [47:0] mac_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  port_out;
		logic [47:0] mac_out;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] ip;
		logic [15:0] vrf;
		logic [7:0]  port;
		logic [47:0] mac;
	} entry_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} mix_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int k);
		return (x << k) | (x >> (32 - k));
	endfunction

	// One line of the final mix: one xor, one rotate and one subtract.
	function automatic mix_t mix_step(input mix_t s, input logic [2:0] step);
		mix_t r;
		r = s;
		case (step)
			3'd0: r.c = (s.c ^ s.b) - rotl32(s.b, 14);
			3'd1: r.a = (s.a ^ s.c) - rotl32(s.c, 11);
			3'd2: r.b = (s.b ^ s.a) - rotl32(s.a, 25);
			3'd3: r.c = (s.c ^ s.b) - rotl32(s.b, 16);
			3'd4: r.a = (s.a ^ s.c) - rotl32(s.c, 4);
			3'd5: r.b = (s.b ^ s.a) - rotl32(s.a, 14);
			3'd6: r.c = (s.c ^ s.b) - rotl32(s.b, 24);
			default: r = s;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/arp_set_assoc_table.sv =====
// Sequence: an accepted item is hashed (seven mix lines, then a mask when SETS
// is a power of two, else a reciprocal remainder), its set row is read, and the
// execute state compares the ways, writes the row back and registers the result.
// A new item is taken only while idle; busy is high from accept until execute ends.
// Reset: a clearing pass zeroes every row, busy is high meanwhile.
// Results are shown for one cycle on done; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// ARP set-associative neighbor table
// Keyed by (vrf, IPv4 address); stores port and MAC in a row-per-set memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arp_set_assoc_table_defines.svh"

module arp_set_assoc_table import arp_sat_pkg::*; #(
	parameter int SETS = 256,
	parameter int WAYS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t request,
	output logic      done,
	output rsp_t      result
);

	localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int ROW_W   = WAYS * $bits(entry_t);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_HASH  = 2'd2;
	localparam logic [1:0] S_EXEC  = 2'd3;

	logic [1:0]          state_q;
	logic [SET_W-1:0]    clr_q;
	logic [SET_W-1:0]    set_q;
	req_t                req_q;
	rsp_t                result_q;
	logic                done_q;
	logic                accept;

	logic                hash_done;
	logic [SET_W-1:0]    hash_set;

	logic                mem_we;
	logic [SET_W-1:0]    mem_waddr;
	logic [ROW_W-1:0]    mem_wdata;
	logic                mem_re;
	logic [ROW_W-1:0]    mem_rdata;

	entry_t [WAYS-1:0]   rd_row;
	entry_t [WAYS-1:0]   wr_row;
	logic                exec_we;
	rsp_t                exec_rsp;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Set index hash.
	arp_sat_hash #(
		.SETS(SETS)
	) u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.word0   ({16'd0, request.vrf_id}),
		.word1   (request.ip_address),
		.done    (hash_done),
		.set_idx (hash_set)
	);

	// Row memory: clearing pass after reset, write-back in the execute cycle.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = set_q;
		mem_wdata = wr_row;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == S_EXEC) begin
			mem_we = exec_we;
		end
	end

	assign mem_re = (state_q == S_HASH) && hash_done;

	arp_sat_row_mem #(
		.ROWS  (SETS),
		.WIDTH (ROW_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (hash_set),
		.rdata (mem_rdata)
	);

	assign rd_row = mem_rdata;

	// Way compare and row update.
	arp_sat_way_exec #(
		.WAYS(WAYS)
	) u_exec (
		.row_req (req_q),
		.row_in  (rd_row),
		.row_out (wr_row),
		.row_we  (exec_we),
		.rsp     (exec_rsp)
	);

	// Control sequence: clear, wait for an item, hash, read, execute.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == SET_W'(SETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item capture, set index and result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (mem_re) begin
			set_q <= hash_set;
		end
		if (state_q == S_EXEC) begin
			result_q <= exec_rsp;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`ARP_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe longer than one cycle")
	`ARP_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy not raised after accept")
	`ARP_ASSERT_SAME(a_idle_no_write, clk, arst_n, state_q == S_IDLE, !mem_we, "row write while idle")
	`ARP_ASSERT_SAME(a_done_idle, clk, arst_n, done, state_q == S_IDLE, "result shown while not idle")
	`ARP_ASSERT_SAME(a_miss_zero, clk, arst_n, done && result.status != ST_OK, result.port_out == '0 && result.mac_out == '0, "nonzero data on failed item")

endmodule

`default_nettype wire

// ===== rtl/arp_sat_hash.sv =====
// ----------------------------------------------------------------------------
// ARP table set hash
// Iterative hashword of the two key words, one mix line per cycle, then a
// reduction to the set count (a mask, or a reciprocal multiply then remainder).
// ----------------------------------------------------------------------------
`default_nettype none

module arp_sat_hash import arp_sat_pkg::*; #(
	parameter int SETS = 256,
	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic [31:0]      word0,
	input  wire logic [31:0]      word1,
	output logic                  done,
	output logic [SET_W-1:0]      set_idx
);

	localparam bit IS_POW2 = ((SETS & (SETS - 1)) == 0);
	// Rounded-up reciprocal of the set count; exact for every 32-bit hash.
	localparam logic [32:0] RECIP =
		33'(((64'd1 << (32 + SET_W)) + 64'(SETS) - 64'd1) / 64'(SETS));
	localparam logic [31:0] SETS_W32 = 32'(SETS);

	localparam logic [1:0] H_IDLE = 2'd0;
	localparam logic [1:0] H_MIX  = 2'd1;
	localparam logic [1:0] H_MUL  = 2'd2;
	localparam logic [1:0] H_REM  = 2'd3;

	logic [1:0]       st_q;
	logic [2:0]       step_q;
	mix_t             mix_q;
	mix_t             mix_nxt;
	logic [64:0]      prod_q;
	logic [31:0]      quot;
	logic [31:0]      rem_val;
	logic [SET_W-1:0] set_q;
	logic             done_q;

	// Next mix line, and the quotient and remainder of the final hash.
	always_comb begin
		mix_nxt = mix_step(mix_q, step_q);
		quot    = 32'(prod_q >> (32 + SET_W));
		rem_val = mix_q.c - quot * SETS_W32;
	end

	// Control sequence of the hash unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= H_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				H_IDLE: begin
					if (load) begin
						step_q <= '0;
						st_q   <= H_MIX;
					end
				end
				H_MIX: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'(MIX_STEPS - 1)) begin
						if (IS_POW2) begin
							done_q <= 1'b1;
							st_q   <= H_IDLE;
						end else begin
							st_q <= H_MUL;
						end
					end
				end
				H_MUL: begin
					st_q <= H_REM;
				end
				H_REM: begin
					done_q <= 1'b1;
					st_q   <= H_IDLE;
				end
				default: st_q <= H_IDLE;
			endcase
		end
	end

	// Mixing state, reciprocal product and the set index.
	always_ff @(posedge clk) begin
		case (st_q)
			H_IDLE: begin
				if (load) begin
					mix_q.a <= HASH_INIT + word0;
					mix_q.b <= HASH_INIT + word1;
					mix_q.c <= HASH_INIT;
				end
			end
			H_MIX: begin
				mix_q <= mix_nxt;
				if (step_q == 3'(MIX_STEPS - 1) && IS_POW2) begin
					set_q <= (SETS == 1) ? '0 : mix_nxt.c[SET_W-1:0];
				end
			end
			H_MUL: begin
				prod_q <= {33'd0, mix_q.c} * {32'd0, RECIP};
			end
			H_REM: begin
				set_q <= rem_val[SET_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign done    = done_q;
	assign set_idx = set_q;

endmodule

`default_nettype wire

// ===== rtl/arp_sat_row_mem.sv =====
// ----------------------------------------------------------------------------
// ARP table row memory
// One row per set holding all ways; one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_sat_row_mem #(
	parameter int ROWS  = 256,
	parameter int WIDTH = 840,
	localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem_q [ROWS];
	logic [WIDTH-1:0] rdata_q;

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/arp_sat_way_exec.sv =====
// ----------------------------------------------------------------------------
// ARP table way compare and update
// Compares the key against every way of a set row, picks the first hit or
// the first free way, and forms the written-back row and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_sat_way_exec import arp_sat_pkg::*; #(
	parameter int WAYS = 8
) (
	input  wire req_t                row_req,
	input  wire entry_t [WAYS-1:0]   row_in,
	output entry_t [WAYS-1:0]        row_out,
	output logic                     row_we,
	output rsp_t                     rsp
);

	logic [WAYS-1:0] hit_v;
	logic [WAYS-1:0] free_v;
	logic [WAYS-1:0] hit_oh;
	logic [WAYS-1:0] free_oh;
	logic [WAYS-1:0] sel_oh;
	logic            hit_any;
	logic            free_any;
	logic [7:0]      hit_port;
	logic [47:0]     hit_mac;
	entry_t          new_entry;

	// Per-way match and free flags; lowest set bit picks the first way.
	always_comb begin
		hit_port = '0;
		hit_mac  = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_v[w]  = row_in[w].valid && (row_in[w].ip == row_req.ip_address)
				&& (row_in[w].vrf == row_req.vrf_id);
			free_v[w] = !row_in[w].valid;
		end
		hit_oh   = hit_v & (~hit_v + WAYS'(1));
		free_oh  = free_v & (~free_v + WAYS'(1));
		hit_any  = |hit_v;
		free_any = |free_v;
		for (int w = 0; w < WAYS; w++) begin
			hit_port = hit_port | (row_in[w].port & {8{hit_oh[w]}});
			hit_mac  = hit_mac | (row_in[w].mac & {48{hit_oh[w]}});
		end
	end

	// Opcode decode: which way is rewritten and what the result item says.
	always_comb begin
		new_entry       = '0;
		new_entry.valid = 1'b1;
		new_entry.ip    = row_req.ip_address;
		new_entry.vrf   = row_req.vrf_id;
		new_entry.port  = row_req.port_in;
		new_entry.mac   = row_req.mac_in;
		sel_oh          = '0;
		row_we          = 1'b0;
		rsp             = '0;
		rsp.status      = ST_OK;
		row_out         = row_in;
		case (row_req.opcode)
			OP_INSERT: begin
				if (hit_any || free_any) begin
					sel_oh = hit_any ? hit_oh : free_oh;
					row_we = 1'b1;
					for (int w = 0; w < WAYS; w++) begin
						if (sel_oh[w]) begin
							row_out[w] = new_entry;
						end
					end
				end else begin
					rsp.status = ST_SET_FULL;
				end
			end
			OP_REMOVE: begin
				if (hit_any) begin
					row_we = 1'b1;
					for (int w = 0; w < WAYS; w++) begin
						if (hit_oh[w]) begin
							row_out[w].valid = 1'b0;
						end
					end
				end else begin
					rsp.status = ST_NOT_FOUND;
				end
			end
			OP_LOOKUP: begin
				if (hit_any) begin
					rsp.port_out = hit_port;
					rsp.mac_out  = hit_mac;
				end else begin
					rsp.status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
